### hdl/assert_macros.svh
// Assertion macros used by the top RTL file of the scanline predictor filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled at the rising clock, off while reset is asserted.
`define SPF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next.
`define SPF_ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (nxt)) \
        else $error(msg);

`endif

### hdl/spf_pkg.sv
// Package with sizes, mode codes and the register index codes of the filter.
package spf_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int LW_W      = 13;
    localparam int CMP_W     = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
    localparam int PIX_W     = 8;
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 2;

    localparam logic [MODE_W-1:0] MODE_NONE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UP         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AVG        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PAETH      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BAD_PAETH  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_AVG    = 3'd6;

    localparam logic [IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_DECODE_MODE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = 2'd2;

    localparam logic [LW_W-1:0] LINE_WIDTH_RESET  = 13'd4096;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [COL_W-1:0] col_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              col_zero;
        logic              first_row;
    } pred_ctrl_t;

endpackage

### hdl/spf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/spf_predict.sv
// Predictor selection from the left, upper and upper-left neighbors.
module spf_predict
    import spf_pkg::*;
(
    input  pix_t       a,
    input  pix_t       b,
    input  pix_t       c,
    input  pred_ctrl_t ctrl,
    output pix_t       pred
);

    logic [PIX_W:0]   sum_ab;
    logic [PIX_W:0]   sum_cc;
    logic [PIX_W-1:0] pa;
    logic [PIX_W-1:0] pb;
    logic [PIX_W:0]   pc;
    pix_t             paeth;
    pix_t             bp;
    pix_t             bda;
    pix_t             bdb;
    pix_t             bdc;
    pix_t             bad_paeth;
    pix_t             bad_avg;
    pix_t             diff_ba;
    pix_t             diff_ab;
    pix_t             avg;

    always_comb begin
        sum_ab = {1'b0, a} + {1'b0, b};
        sum_cc = {1'b0, c} + {1'b0, c};
        pa = (b >= c) ? b - c : c - b;
        pb = (a >= c) ? a - c : c - a;
        pc = (sum_ab >= sum_cc) ? sum_ab - sum_cc : sum_cc - sum_ab;
        if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
            paeth = a;
        end else if ({1'b0, pb} <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end

        bp  = a + b - c;
        bda = a - bp;
        bdb = b - bp;
        bdc = c - bp;
        if (bda <= bdb && bda <= bdc) begin
            bad_paeth = a;
        end else if (bdb <= bdc) begin
            bad_paeth = b;
        end else begin
            bad_paeth = c;
        end

        diff_ab = a - b;
        diff_ba = b - a;
        if (a >= b) begin
            bad_avg = diff_ab >> 1;
        end else begin
            bad_avg = pix_t'(9'h100 - {2'b00, diff_ba[PIX_W-1:1]});
        end

        avg = sum_ab[PIX_W:1];

        pred = '0;
        if (!ctrl.col_zero) begin
            if (ctrl.mode == MODE_SUB) begin
                pred = a;
            end else if (!ctrl.first_row) begin
                case (ctrl.mode)
                    MODE_UP:        pred = b;
                    MODE_AVG:       pred = avg;
                    MODE_PAETH:     pred = paeth;
                    MODE_BAD_PAETH: pred = bad_paeth;
                    MODE_BAD_AVG:   pred = bad_avg;
                    default:        pred = '0;
                endcase
            end
        end
    end

endmodule

### hdl/scanline_predictor_filter.sv
// Scanline predictor filter: one 8-bit sample in, one filtered sample out.
// Each accepted request moves through the s1 registers to the m_* output registers.
// Throughput is one request per cycle unless m_tready stalls. The line store is read
// on accept and written back as the request leaves s1, with a bypass for the same column.
// Reset (aresetn low, synchronous) clears the counters, neighbors, config and valid flags;
// the line store is not cleared; the user, not the block, must see it is written before it is read.
`include "assert_macros.svh"

module scanline_predictor_filter
    import spf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] sample_in
    input  logic              s_tuser,   // plane_start
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] sample_out
    output logic              m_tlast,   // row_end
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [LW_W-1:0]   cfg_wdata
);

    logic [MODE_W-1:0] filter_mode_reg;
    logic              decode_mode_reg;
    logic [LW_W-1:0]   line_width_reg;

    col_t              column_count_reg;
    logic              first_row_reg;
    pix_t              left_reg;
    pix_t              upper_left_reg;

    logic              s1_valid_reg;
    pix_t              s1_sample_reg;
    col_t              s1_col_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic              fwd_valid_reg;
    pix_t              fwd_data_reg;

    logic              m_valid_reg;
    pix_t              m_data_reg;
    logic              m_last_reg;

    logic              s_acc;
    logic              s1_adv;
    logic [CMP_W-1:0]  width_eff;
    col_t              s0_col;
    logic              s0_first;
    logic              s0_last;
    logic [CMP_W-1:0]  s0_col_inc;
    pix_t              ram_rdata;
    pix_t              up_b;
    pix_t              pred;
    pix_t              res;
    pix_t              v;
    pred_ctrl_t        pctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg <= MODE_NONE;
            decode_mode_reg <= 1'b0;
            line_width_reg  <= LINE_WIDTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FILTER_MODE: filter_mode_reg <= cfg_wdata[MODE_W-1:0];
                REG_DECODE_MODE: decode_mode_reg <= cfg_wdata[0];
                REG_LINE_WIDTH:  line_width_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        if (line_width_reg == '0) begin
            width_eff = CMP_W'(1);
        end else if (CMP_W'(line_width_reg) > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end else begin
            width_eff = CMP_W'(line_width_reg);
        end
        s0_col     = s_tuser ? '0 : column_count_reg;
        s0_first   = s_tuser ? 1'b1 : first_row_reg;
        s0_col_inc = CMP_W'(s0_col) + CMP_W'(1);
        s0_last    = (s0_col_inc >= width_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            first_row_reg    <= 1'b1;
        end else if (s_acc) begin
            column_count_reg <= s0_last ? '0 : s0_col_inc[COL_W-1:0];
            first_row_reg    <= s0_last ? 1'b0 : s0_first;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= s1_adv && (s0_col == s1_col_reg);
            end else if (s1_adv) begin
                s1_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_sample_reg <= s_tdata;
            s1_col_reg    <= s0_col;
            s1_first_reg  <= s0_first;
            s1_last_reg   <= s0_last;
            fwd_data_reg  <= v;
        end
    end

    spf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (v),
        .re    (s_acc),
        .raddr (s0_col),
        .rdata (ram_rdata)
    );

    assign up_b = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    assign pctrl.mode      = filter_mode_reg;
    assign pctrl.col_zero  = (s1_col_reg == '0);
    assign pctrl.first_row = s1_first_reg;

    spf_predict u_predict (
        .a    (left_reg),
        .b    (up_b),
        .c    (upper_left_reg),
        .ctrl (pctrl),
        .pred (pred)
    );

    assign res = decode_mode_reg ? s1_sample_reg + pred : s1_sample_reg - pred;
    assign v   = decode_mode_reg ? res : s1_sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            upper_left_reg <= '0;
        end else if (s1_adv) begin
            left_reg       <= v;
            upper_left_reg <= up_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= res;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `SPF_ASSERT_NEXT(a_accept_reaches_s1, aclk, aresetn, s_acc, s1_valid_reg, "accepted request did not reach the second stage")
    `SPF_ASSERT_NEXT(a_row_end_wraps, aclk, aresetn, s_acc && s0_last, column_count_reg == '0 && !first_row_reg, "column count did not wrap at row end")
    `SPF_ASSERT_NEXT(a_bypass_on_same_col, aclk, aresetn, s_acc && s1_adv && (s0_col == s1_col_reg), fwd_valid_reg, "same-column write was not forwarded")
    `SPF_ASSERT_NEXT(a_output_held_on_stall, aclk, aresetn, m_valid_reg && !m_tready, m_valid_reg && $stable(m_data_reg) && $stable(m_last_reg), "waiting result changed")

endmodule

### dv/tb_scanline_predictor_filter.sv
// Self-checking testbench for the scanline predictor filter: directed and random planes.
`timescale 1ns / 1ps

module tb_scanline_predictor_filter;
    import spf_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [7:0] sample;
        logic       row_end;
    } pixel_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [7:0] sample_in
    logic             s_tuser;   // plane_start
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // [7:0] sample_out
    logic             m_tlast;   // row_end
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [LW_W-1:0]  cfg_wdata;

    // Filter state and register copies mirrored by the testbench.
    logic [7:0]        row_above [MAX_WIDTH];
    logic [7:0]        left_px;
    logic [7:0]        upper_left_px;
    int unsigned       col_pos;
    logic              first_row;
    logic [MODE_W-1:0] filt_mode;
    logic              decode_on;
    logic [LW_W-1:0]   line_width_cfg;
    // Line store entries below this column have been written at least once.
    int unsigned       stored_cols;

    pixel_result_t expected_pixels [$];
    int error_count;
    int results_checked;
    int quiet_cycles;
    bit idle_on;

    scanline_predictor_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void predict_sample(input logic [7:0] s, input logic start,
                                           output logic [7:0] res, output logic last);
        int unsigned w;
        int unsigned col;
        int a, b, c, p, da, db, dc, pred;
        bit pick;
        logic [7:0] p8;
        logic [7:0] kept;
        w = line_width_cfg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (start) begin
            col_pos = 0;
            first_row = 1'b1;
        end
        col = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        a = left_px;
        b = row_above[col];
        c = upper_left_px;
        pred = 0;
        pick = 1'b0;
        da = 0;
        db = 0;
        dc = 0;
        if (col != 0) begin
            if (filt_mode == MODE_SUB) begin
                pred = a;
            end else if (!first_row) begin
                case (filt_mode)
                    MODE_UP: pred = b;
                    MODE_AVG: pred = (a + b) / 2;
                    MODE_PAETH: begin
                        da = (b > c) ? b - c : c - b;
                        db = (a > c) ? a - c : c - a;
                        dc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
                        pick = 1'b1;
                    end
                    MODE_BAD_PAETH: begin
                        // Estimate and distances all wrap to eight bits.
                        p  = (a + b - c) & 255;
                        da = (a - p) & 255;
                        db = (b - p) & 255;
                        dc = (c - p) & 255;
                        pick = 1'b1;
                    end
                    MODE_BAD_AVG: pred = (a - b) / 2;
                    default: pred = 0;
                endcase
            end
        end
        if (pick) pred = (da <= db && da <= dc) ? a : ((db <= dc) ? b : c);
        p8 = 8'(pred);
        res = decode_on ? s + p8 : s - p8;
        kept = decode_on ? res : s;
        upper_left_px = 8'(b);
        row_above[col] = kept;
        if (col == stored_cols) stored_cols++;
        left_px = kept;
        last = (col + 1 >= w);
        if (last) begin
            col_pos = 0;
            first_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    task automatic flag_mismatch(input string what, input int expv, input int gotv);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: %s at result %0d: expected %0d, got %0d",
                     $time, what, results_checked, expv, gotv);
    endtask

    always @(posedge aclk) begin : predict_requests
        pixel_result_t exp_px;
        if (aresetn && s_tvalid && s_tready) begin
            predict_sample(s_tdata, s_tuser, exp_px.sample, exp_px.row_end);
            expected_pixels.push_back(exp_px);
        end
    end

    always @(posedge aclk) begin : check_results
        pixel_result_t exp_px;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                flag_mismatch("result with no request pending", -1, m_tdata);
            end else begin
                exp_px = expected_pixels.pop_front();
                if (m_tdata !== exp_px.sample)
                    flag_mismatch("sample_out mismatch", exp_px.sample, m_tdata);
                if (m_tlast !== exp_px.row_end)
                    flag_mismatch("row_end mismatch", exp_px.row_end, m_tlast);
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no request or result moved for %0d cycles.", QUIET_LIMIT);
                $display("[scanline_predictor_filter] ERROR");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 13);
    end

    task automatic send_pixel(input logic [7:0] sample, input logic start);
        if (idle_on && $urandom_range(99) < 13) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [LW_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_FILTER_MODE: filt_mode = value[MODE_W-1:0];
            REG_DECODE_MODE: decode_on = value[0];
            REG_LINE_WIDTH:  line_width_cfg = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_sample();
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    task automatic test_every_mode();
        write_register(REG_LINE_WIDTH, 2);
        write_register(REG_UNUSED, 13'h1FFF);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        settle();
        for (int m = 0; m < 8; m++) begin
            write_register(REG_FILTER_MODE, LW_W'(m));
            write_register(REG_DECODE_MODE, LW_W'(m % 2));
            send_pixel(8'($urandom_range(255)), 1'b0);
            send_pixel((m % 2) ? 8'h00 : 8'hFF, 1'b0);
            settle();
        end
    endtask

    task automatic test_width_edges();
        write_register(REG_FILTER_MODE, LW_W'(MODE_PAETH));
        write_register(REG_LINE_WIDTH, 0);
        send_pixel(8'h80, 1'b1);
        send_pixel(8'h01, 1'b0);
        settle();
        write_register(REG_LINE_WIDTH, 13'h1FFF);
        send_pixel(8'h10, 1'b1);
        send_pixel(8'hFE, 1'b0);
        send_pixel(8'h7F, 1'b0);
        settle();
        // Shrinking below the current column must close the row.
        write_register(REG_LINE_WIDTH, 2);
        send_pixel(8'h55, 1'b0);
        settle();
    endtask

    task automatic test_random_planes();
        int sent, r, w_eff, n, restart_at;
        bit fresh;
        logic [LW_W-1:0] value;
        sent = 0;
        while (sent < 1000) begin
            idle_on = !(sent >= 400 && sent < 600);
            if ($urandom_range(99) < 70) begin
                value = LW_W'($urandom);
                write_register(REG_FILTER_MODE, value);
            end
            if ($urandom_range(99) < 50) begin
                value = LW_W'($urandom);
                write_register(REG_DECODE_MODE, value);
            end
            if ($urandom_range(99) < 70) begin
                r = $urandom_range(99);
                if (r < 5) value = 0;
                else if (r < 9) value = 1;
                else if (r < 12) value = 13'h1FFF;
                else if (r < 16) value = LINE_WIDTH_RESET;
                else if (r < 80) value = LW_W'($urandom_range(12, 2));
                else value = LW_W'($urandom_range(200, 13));
                write_register(REG_LINE_WIDTH, value);
            end
            w_eff = (line_width_cfg == 0) ? 1 :
                    (line_width_cfg > MAX_WIDTH) ? MAX_WIDTH : line_width_cfg;
            n = w_eff * $urandom_range(4, 1);
            if (n > 300) n = 300;
            if ($urandom_range(99) < 20) n = $urandom_range(n, 1);
            fresh = ($urandom_range(99) < 85);
            // A later row may only read columns that some earlier row wrote.
            if (!first_row && w_eff > stored_cols) fresh = 1'b1;
            restart_at = (n > 1 && $urandom_range(99) < 10) ? $urandom_range(n - 1, 1) : -1;
            for (int i = 0; i < n; i++) begin
                send_pixel(pick_sample(), (i == 0 && fresh) || i == restart_at);
                sent++;
            end
            settle();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        idle_on   = 1'b1;
        error_count = 0;
        results_checked = 0;
        quiet_cycles = 0;
        for (int i = 0; i < MAX_WIDTH; i++) row_above[i] = '0;
        left_px        = '0;
        upper_left_px  = '0;
        col_pos        = 0;
        first_row      = 1'b1;
        filt_mode      = MODE_NONE;
        decode_on      = 1'b0;
        line_width_cfg = LINE_WIDTH_RESET;
        stored_cols    = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_every_mode();
        test_width_edges();
        test_random_planes();

        settle();
        repeat (5) @(posedge aclk);
        if (expected_pixels.size() != 0)
            flag_mismatch("results never delivered", expected_pixels.size(), 0);
        if (error_count == 0) begin
            $display("[scanline_predictor_filter] OK");
        end else begin
            $display("[scanline_predictor_filter] ERROR");
        end
        $finish;
    end

endmodule

### scanline_predictor_filter.f
+incdir+hdl
hdl/spf_pkg.sv
hdl/spf_ram.sv
hdl/spf_predict.sv
hdl/scanline_predictor_filter.sv
dv/tb_scanline_predictor_filter.sv
